[design/vps_pkg.sv]
`timescale 1ns / 1ps

package vps_pkg;

  // Default tick counter width; the phase counter saturates at this width and the ring period is truncated to it.
  localparam int unsigned TickBitsDefault = 16;

  // Width of the on-time, which is at most three times the strong base (270).
  localparam int unsigned OnLenBits = 9;

  // Action codes of an input item.
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_BUZZ = 2'd1;
  localparam logic [1:0] ACT_RING = 2'd2;
  localparam logic [1:0] ACT_STOP = 2'd3;

  // Intensity codes; the unused code acts as strong.
  localparam logic [1:0] LVL_LIGHT  = 2'd0;
  localparam logic [1:0] LVL_MEDIUM = 2'd1;
  localparam logic [1:0] LVL_STRONG = 2'd2;
  localparam logic [1:0] LVL_SPARE  = 2'd3;

  // Base on-time per intensity, in ticks.
  localparam logic [OnLenBits-1:0] BaseLight  = 9'd30;
  localparam logic [OnLenBits-1:0] BaseMedium = 9'd50;
  localparam logic [OnLenBits-1:0] BaseStrong = 9'd90;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  intensity;
    logic [15:0] shake_speed;
    logic [15:0] ring_period;
    logic [15:0] buzz_count;
  } item_t;

  typedef struct packed {
    logic motor_on;
    logic ringing;
    logic busy_res;
  } result_t;

endpackage

[design/vibration_pattern_sequencer_unit.sv]
`timescale 1ns / 1ps

// Vibration pattern sequencer. Each input transfer carries one action (tick,
// buzz request, ring request or stop) and produces exactly one result
// transfer telling whether the motor is driven, whether a ring is in
// progress and whether any pattern is active after that action. A buzz
// drives the motor for the on-time, then goes idle; a ring alternates the
// on-time with ring_period minus the on-time (at least one tick), for
// buzz_count pulses or forever when buzz_count is zero. The on-time is
// base*shake_speed/200 clamped to base..3*base, base 30/50/90 by intensity.
// Rate: one item per clock while the result side does not stall; an item
// passes the input register, then the state update that loads the result
// register. Phase and period counters are TICK_BITS wide; the phase saturates
// and the ring period is truncated. No clearing pass is needed after reset.
module vibration_pattern_sequencer_unit #(
  parameter int unsigned TICK_BITS = vps_pkg::TickBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  vps_pkg::item_t  item,
  output logic            res_valid,
  input  logic            res_stall,
  output vps_pkg::result_t res
);

  localparam int unsigned OnBits = vps_pkg::OnLenBits;
  // Working width wide enough for the ring period, the on-time and the counter.
  localparam int unsigned WideBits = (TICK_BITS > 16) ? TICK_BITS : 16;
  localparam logic [WideBits-1:0] TickMax = WideBits'({TICK_BITS{1'b1}});
  localparam logic [TICK_BITS-1:0] TickOne = TICK_BITS'(1);

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_BUZZ     = 4'b0010,
    MODE_RING_ON  = 4'b0100,
    MODE_RING_OFF = 4'b1000
  } mode_t;

  // Input register
  logic           s1_valid;
  vps_pkg::item_t s1_item;
  logic           advance;

  // Pattern state
  mode_t                 mode, mode_next;
  logic [TICK_BITS-1:0]  phase_left, phase_left_next;
  logic [OnBits-1:0]     on_length, on_length_next;
  logic [TICK_BITS-1:0]  cycle_period, cycle_period_next;
  logic [15:0]           pulses_left, pulses_left_next;

  logic [OnBits-1:0]     req_on_len;
  logic [TICK_BITS-1:0]  phase_dec;
  logic [WideBits-1:0]   off_wide;
  logic [WideBits-1:0]   period_wide;
  logic [WideBits-1:0]   period_in_wide;

  // Clamp an on-time to the counter range; it is never below 30.
  function automatic logic [TICK_BITS-1:0] sat_on(input logic [OnBits-1:0] len);
    logic [WideBits-1:0] w;
    w = WideBits'(len);
    if (w > TickMax) begin
      w = TickMax;
    end
    return w[TICK_BITS-1:0];
  endfunction

  vps_on_time u_on_time (
    .intensity   (s1_item.intensity),
    .shake_speed (s1_item.shake_speed),
    .on_len      (req_on_len)
  );

  // Move the held item into the result register whenever that register is
  // empty or its content is being taken this cycle.
  assign advance    = s1_valid && (!res_valid || !res_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  assign period_in_wide = WideBits'(s1_item.ring_period);
  assign period_wide    = WideBits'(cycle_period);
  assign phase_dec      = (phase_left == '0) ? '0 : phase_left - TickOne;
  // Off time: period minus on-time, saturated at zero; never exceeds the period.
  assign off_wide = (period_wide > WideBits'(on_length)) ?
                    period_wide - WideBits'(on_length) : '0;

  always_comb begin
    mode_next         = mode;
    phase_left_next   = phase_left;
    on_length_next    = on_length;
    cycle_period_next = cycle_period;
    pulses_left_next  = pulses_left;
    if (advance) begin
      case (s1_item.action)
        vps_pkg::ACT_BUZZ, vps_pkg::ACT_RING: begin
          // Restart the pattern from its on phase.
          on_length_next  = req_on_len;
          phase_left_next = sat_on(req_on_len);
          if (s1_item.action == vps_pkg::ACT_BUZZ) begin
            mode_next = MODE_BUZZ;
          end else begin
            mode_next         = MODE_RING_ON;
            cycle_period_next = period_in_wide[TICK_BITS-1:0];
            pulses_left_next  = s1_item.buzz_count;
          end
        end
        vps_pkg::ACT_STOP: begin
          mode_next       = MODE_IDLE;
          phase_left_next = '0;
        end
        default: begin
          if (mode != MODE_IDLE) begin
            phase_left_next = phase_dec;
            if (phase_dec == '0) begin
              case (mode)
                MODE_BUZZ: begin
                  mode_next = MODE_IDLE;
                end
                MODE_RING_ON: begin
                  if (pulses_left == 16'd1) begin
                    mode_next = MODE_IDLE;
                  end else begin
                    if (pulses_left > 16'd1) begin
                      pulses_left_next = pulses_left - 16'd1;
                    end
                    mode_next = MODE_RING_OFF;
                    phase_left_next = (off_wide == '0) ? TickOne :
                                      off_wide[TICK_BITS-1:0];
                  end
                end
                MODE_RING_OFF: begin
                  mode_next       = MODE_RING_ON;
                  phase_left_next = sat_on(on_length);
                end
                default: begin
                  mode_next = MODE_IDLE;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      phase_left   <= '0;
      on_length    <= '0;
      cycle_period <= '0;
      pulses_left  <= '0;
    end else begin
      mode         <= mode_next;
      phase_left   <= phase_left_next;
      on_length    <= on_length_next;
      cycle_period <= cycle_period_next;
      pulses_left  <= pulses_left_next;
    end
  end

  // Result register: load on advance, drop once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.motor_on <= (mode_next == MODE_BUZZ) || (mode_next == MODE_RING_ON);
      res.ringing  <= (mode_next == MODE_RING_ON) || (mode_next == MODE_RING_OFF);
      res.busy_res <= (mode_next != MODE_IDLE);
    end
  end

  // An active pattern always has time left in its phase.
  a_phase_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_IDLE) |-> (phase_left != '0))
    else $error("active pattern with empty phase");

  // A stored on-time lies within the clamp range of some intensity.
  a_on_range: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_IDLE) |-> (on_length >= vps_pkg::BaseLight &&
                             on_length <= OnBits'(3 * vps_pkg::BaseStrong)))
    else $error("on-time out of range");

  // A driven motor or a ring implies a busy result.
  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((!res.motor_on && !res.ringing) || res.busy_res))
    else $error("result flags inconsistent");

  // State changes only when an item moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(mode) && $stable(phase_left))
    else $error("state changed without an item");

  // The input side stalls only while an item is held and cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && res_valid && res_stall))
    else $error("stall without a blocked result");

endmodule

[design/vps_on_time.sv]
`timescale 1ns / 1ps

// On-time = base * shake / 200, truncated, clamped to base .. 3*base.
// Outside shake 200..599 the clamp decides, so only a 10-bit shake is scaled,
// by a fixed-point reciprocal of 200/base (exact over that range).
module vps_on_time (
  input  logic [1:0]                       intensity,
  input  logic [15:0]                      shake_speed,
  output logic [vps_pkg::OnLenBits-1:0]    on_len
);

  localparam int unsigned FracBits = 16;
  // ceil(base / 200 * 2^16) for 30, 50 and 90.
  localparam logic [14:0] RecipLight  = 15'd9831;
  localparam logic [14:0] RecipMedium = 15'd16384;
  localparam logic [14:0] RecipStrong = 15'd29492;
  localparam logic [15:0] ShakeLow    = 16'd200;
  localparam logic [15:0] ShakeHigh   = 16'd600;

  logic [vps_pkg::OnLenBits-1:0] base;
  logic [vps_pkg::OnLenBits-1:0] base_x3;
  logic [14:0]                   recip;
  logic [24:0]                   product;
  logic [vps_pkg::OnLenBits-1:0] scaled;

  always_comb begin
    case (intensity)
      vps_pkg::LVL_LIGHT: begin
        base  = vps_pkg::BaseLight;
        recip = RecipLight;
      end
      vps_pkg::LVL_MEDIUM: begin
        base  = vps_pkg::BaseMedium;
        recip = RecipMedium;
      end
      default: begin
        base  = vps_pkg::BaseStrong;
        recip = RecipStrong;
      end
    endcase
  end

  assign base_x3 = vps_pkg::OnLenBits'({base, 1'b0} + {1'b0, base});
  assign product = 25'(shake_speed[9:0]) * 25'(recip);
  assign scaled  = product[FracBits +: vps_pkg::OnLenBits];

  always_comb begin
    if (shake_speed < ShakeLow) begin
      on_len = base;
    end else if (shake_speed >= ShakeHigh) begin
      on_len = base_x3;
    end else begin
      on_len = scaled;
    end
  end

endmodule
